@@ rtl/cmae_pkg.sv @@
// shared types, constants and helpers for the complex matrix engine
`timescale 1ns / 1ps
package cmae_pkg;

  localparam int MAX_DIM     = 8;
  localparam int VALUE_WIDTH = 16;
  localparam int FRAC_BITS   = 8;
  localparam int IDX_W       = 3;
  localparam int DIM_W       = 4;
  localparam int ADDR_W      = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int PROD_W      = 2 * VALUE_WIDTH + 1;
  localparam int ACC_W       = PROD_W + 4;

  typedef enum logic [1:0] {
    MODE_LOAD_A = 2'd0,
    MODE_LOAD_B = 2'd1,
    MODE_RUN    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_ADD_B   = 2'd0,
    OP_MUL_B   = 2'd1,
    OP_MUL_SC  = 2'd2,
    OP_ADD_SC  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_A_ROWS    = 3'd0,
    CFG_A_COLS    = 3'd1,
    CFG_B_ROWS    = 3'd2,
    CFG_B_COLS    = 3'd3,
    CFG_OPERATION = 3'd4,
    CFG_SCALAR_RE = 3'd5,
    CFG_SCALAR_IM = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]                    mode;
    logic [IDX_W-1:0]              row;
    logic [IDX_W-1:0]              col;
    logic signed [VALUE_WIDTH-1:0] value_re;
    logic signed [VALUE_WIDTH-1:0] value_im;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]              out_row;
    logic [IDX_W-1:0]              out_col;
    logic signed [VALUE_WIDTH-1:0] result_re;
    logic signed [VALUE_WIDTH-1:0] result_im;
    logic                          dims_mismatch;
    logic                          last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic             write_a;
    logic             write_b;
    logic             read;
    logic             acc_clear;
    logic             mac;
    logic             finish;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             mis;
    logic             last;
  } dp_cmd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return DIM_W'(1);
    if (d > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return d;
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] sat_acc(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
    lo = -hi - ACC_W'(1);
    if (v > hi) return hi[VALUE_WIDTH-1:0];
    if (v < lo) return lo[VALUE_WIDTH-1:0];
    return v[VALUE_WIDTH-1:0];
  endfunction

endpackage

@@ rtl/complex_matrix_arith_engine.sv @@
// top level of the complex matrix engine: config registers, sequencer, datapath
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_data (mode,row,col,value)
// out     | output    | out_valid/out_stall| out_data (index,result,flags)
// cfg     | input     | cfg_we             | cfg_idx, cfg_data
// a load is taken in idle; per element a run does k read and accumulate steps,
// then finish and an output step that waits on out_stall; k = a_cols for A*B
// without mismatch, else 1; one complex MAC unit reads both stores per step
// reset is synchronous active low; stores are not cleared
// input is stalled during a run; a stalled result holds the sequencer
module complex_matrix_arith_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cmae_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cmae_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_idx,
  input  logic [15:0]          cfg_data
);
  import cmae_pkg::*;

  // configuration registers
  logic [DIM_W-1:0]              a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [1:0]                    op_r;
  logic signed [VALUE_WIDTH-1:0] sc_re_r, sc_im_r;
  dp_cmd_t                       cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_W'(MAX_DIM);
      a_cols_r <= DIM_W'(MAX_DIM);
      b_rows_r <= DIM_W'(MAX_DIM);
      b_cols_r <= DIM_W'(MAX_DIM);
      op_r     <= OP_ADD_B;
      sc_re_r  <= '0;
      sc_im_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_A_ROWS:    a_rows_r <= cfg_data[DIM_W-1:0];
        CFG_A_COLS:    a_cols_r <= cfg_data[DIM_W-1:0];
        CFG_B_ROWS:    b_rows_r <= cfg_data[DIM_W-1:0];
        CFG_B_COLS:    b_cols_r <= cfg_data[DIM_W-1:0];
        CFG_OPERATION: op_r     <= cfg_data[1:0];
        CFG_SCALAR_RE: sc_re_r  <= cfg_data;
        CFG_SCALAR_IM: sc_im_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  cmae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_data.mode),
    .a_rows    (a_rows_r),
    .a_cols    (a_cols_r),
    .b_rows    (b_rows_r),
    .b_cols    (b_cols_r),
    .operation (op_r),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // stores and arithmetic
  cmae_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_row    (in_data.row),
    .in_col    (in_data.col),
    .in_re     (in_data.value_re),
    .in_im     (in_data.value_im),
    .operation (op_r),
    .scalar_re (sc_re_r),
    .scalar_im (sc_im_r),
    .out_item  (out_data)
  );
endmodule

@@ rtl/cmae_ctrl.sv @@
// sequencer for loads and runs of the complex matrix engine
`timescale 1ns / 1ps
module cmae_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [3:0]         a_rows,
  input  logic [3:0]         a_cols,
  input  logic [3:0]         b_rows,
  input  logic [3:0]         b_cols,
  input  logic [1:0]         operation,
  output cmae_pkg::dp_cmd_t  cmd,
  output logic               out_valid,
  input  logic               out_stall
);
  import cmae_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             mis_r, mis_nxt;
  logic [DIM_W-1:0] ar, ac, br, bc, rows, cols, kdim;
  logic             acc;
  logic             last_el;

  assign ar = clamp_dim(a_rows);
  assign ac = clamp_dim(a_cols);
  assign br = clamp_dim(b_rows);
  assign bc = clamp_dim(b_cols);
  assign rows = ar;
  assign cols = (operation == OP_MUL_B && !mis_r) ? bc : ac;
  assign kdim = (operation == OP_MUL_B && !mis_r) ? ac : DIM_W'(1);
  assign last_el = ({1'b0, i_r} + 4'd1 == rows) && ({1'b0, j_r} + 4'd1 == cols);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
      mis_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
      mis_r <= mis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    mis_nxt = mis_r;
    in_stall = 1'b1;
    out_valid = 1'b0;
    acc = 1'b0;
    cmd = '0;
    cmd.i = i_r;
    cmd.j = j_r;
    cmd.k = k_r;
    cmd.mis = mis_r;
    cmd.last = last_el;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        acc = in_valid;
        if (acc) begin
          unique case (mode_t'(in_mode))
            MODE_LOAD_A: cmd.write_a = 1'b1;
            MODE_LOAD_B: cmd.write_b = 1'b1;
            MODE_RUN: begin
              mis_nxt = (operation == OP_ADD_B && (ar != br || ac != bc)) ||
                        (operation == OP_MUL_B && ac != br);
              i_nxt = '0;
              j_nxt = '0;
              k_nxt = '0;
              state_nxt = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.read = 1'b1;
        cmd.acc_clear = (k_r == '0);
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        if ({1'b0, k_r} + 4'd1 == kdim) begin
          k_nxt = '0;
          state_nxt = ST_FINISH;
        end else begin
          k_nxt = k_r + IDX_W'(1);
          state_nxt = ST_READ;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (last_el) begin
            state_nxt = ST_IDLE;
          end else if ({1'b0, j_r} + 4'd1 == cols) begin
            j_nxt = '0;
            i_nxt = i_r + IDX_W'(1);
            state_nxt = ST_READ;
          end else begin
            j_nxt = j_r + IDX_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken during a run");
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_OUT))
    else $error("result shown outside output state");
  a_mac_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> $past(state_r) == ST_READ)
    else $error("accumulate step without a read");
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && last_el) |=> (state_r == ST_IDLE))
    else $error("run did not end on last element");
`endif
endmodule

@@ rtl/cmae_datapath.sv @@
// element stores, complex multiply-accumulate and result register
`timescale 1ns / 1ps
module cmae_datapath (
  input  logic                                clk,
  input  cmae_pkg::dp_cmd_t                   cmd,
  input  logic [2:0]                          in_row,
  input  logic [2:0]                          in_col,
  input  logic signed [15:0]                  in_re,
  input  logic signed [15:0]                  in_im,
  input  logic [1:0]                          operation,
  input  logic signed [15:0]                  scalar_re,
  input  logic signed [15:0]                  scalar_im,
  output cmae_pkg::out_item_t                 out_item
);
  import cmae_pkg::*;

  logic [2*VALUE_WIDTH-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic [2*VALUE_WIDTH-1:0] b_mem [MAX_DIM*MAX_DIM];
  logic [2*VALUE_WIDTH-1:0] a_q_r, b_q_r, ael_q_r;
  logic [ADDR_W-1:0]        wr_addr, a_addr, b_addr, ael_addr;
  logic signed [ACC_W-1:0]  acc_re_r, acc_re_nxt, acc_im_r, acc_im_nxt;
  logic signed [VALUE_WIDTH-1:0] xr, xi, yr, yi, er, ei;
  logic signed [PROD_W-1:0] p_re, p_im;
  logic signed [ACC_W-1:0]  sh_re, sh_im;
  logic                     use_sc;
  out_item_t                out_r, out_nxt;

  assign wr_addr = {in_row, in_col};
  assign a_addr  = {cmd.i, cmd.k};
  assign b_addr  = {cmd.k, cmd.j};
  assign ael_addr = {cmd.i, cmd.j};

  always_ff @(posedge clk) begin
    if (cmd.write_a) a_mem[wr_addr] <= {in_re, in_im};
    if (cmd.write_b) b_mem[wr_addr] <= {in_re, in_im};
    if (cmd.read) begin
      a_q_r   <= (operation == OP_MUL_B && !cmd.mis) ? a_mem[a_addr] : a_mem[ael_addr];
      b_q_r   <= (operation == OP_MUL_B) ? b_mem[b_addr] : b_mem[ael_addr];
      ael_q_r <= a_mem[ael_addr];
    end
  end

  // both scalar operations take the scalar as second operand
  assign use_sc = (operation == OP_MUL_SC) || (operation == OP_ADD_SC);

  assign xr = a_q_r[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign xi = a_q_r[VALUE_WIDTH-1:0];
  assign er = ael_q_r[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign ei = ael_q_r[VALUE_WIDTH-1:0];
  assign yr = use_sc ? scalar_re : b_q_r[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign yi = use_sc ? scalar_im : b_q_r[VALUE_WIDTH-1:0];

  // one complex product per step
  assign p_re = PROD_W'(xr * yr) - PROD_W'(xi * yi);
  assign p_im = PROD_W'(xr * yi) + PROD_W'(xi * yr);

  always_comb begin
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (cmd.acc_clear) begin
      acc_re_nxt = '0;
      acc_im_nxt = '0;
    end
    if (cmd.mac) begin
      acc_re_nxt = acc_re_r + ACC_W'(p_re);
      acc_im_nxt = acc_im_r + ACC_W'(p_im);
    end
  end

  always_ff @(posedge clk) begin
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
    out_r    <= out_nxt;
  end

  assign sh_re = acc_re_r >>> FRAC_BITS;
  assign sh_im = acc_im_r >>> FRAC_BITS;

  always_comb begin
    out_nxt = out_r;
    if (cmd.finish) begin
      out_nxt.out_row = cmd.i;
      out_nxt.out_col = cmd.j;
      out_nxt.dims_mismatch = cmd.mis;
      out_nxt.last = cmd.last;
      if (cmd.mis) begin
        out_nxt.result_re = er;
        out_nxt.result_im = ei;
      end else begin
        case (op_t'(operation)) inside
          OP_MUL_B, OP_MUL_SC: begin
            out_nxt.result_re = sat_acc(sh_re);
            out_nxt.result_im = sat_acc(sh_im);
          end
          default: begin
            out_nxt.result_re = sat_acc(ACC_W'(er) + ACC_W'(yr));
            out_nxt.result_im = sat_acc(ACC_W'(ei) + ACC_W'(yi));
          end
        endcase
      end
    end
  end

  assign out_item = out_r;
endmodule
